>>> rtl/mcuenc_pkg.sv
package mcuenc_pkg;

	// Widths of the configuration port.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 4;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CORE_MODE      = 2'd0,
		REG_DATA_BANK_BITS = 2'd1,
		REG_CODE_PAGE_BITS = 2'd2,
		REG_TOP_CODE_PAGE  = 2'd3
	} cfg_reg_e;

	// Reset values of the configuration registers.
	localparam logic       CORE_MODE_RST      = 1'b1;
	localparam logic [2:0] DATA_BANK_BITS_RST = 3'd7;
	localparam logic [3:0] CODE_PAGE_BITS_RST = 4'd11;
	localparam logic [1:0] TOP_CODE_PAGE_RST  = 2'd0;

	// Live configuration, as seen by the encoder.
	typedef struct packed {
		logic       core_mode;
		logic [2:0] data_bank_bits;
		logic [3:0] code_page_bits;
		logic [1:0] top_code_page;
	} cfg_t;

	// One instruction in.
	typedef struct packed {
		logic [5:0]  cmd;
		logic [15:0] operand_one;
		logic [7:0]  operand_two;
	} in_beat_t;

	// One encoded word out.
	typedef struct packed {
		logic [13:0] code_word;
		logic [2:0]  status;
		logic        references_register;
	} out_beat_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_LITERAL = 3'd1,
		ST_DEST    = 3'd2,
		ST_BITNUM  = 3'd3,
		ST_ADDR    = 3'd4,
		ST_BADCMD  = 3'd5
	} status_e;

	// Operand classes.
	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_FD   = 3'd1,
		KIND_F    = 3'd2,
		KIND_B    = 3'd3,
		KIND_LIT  = 3'd4,
		KIND_ADDR = 3'd5,
		KIND_TRIS = 3'd6
	} kind_e;

	// Mnemonic indexes.
	typedef enum logic [5:0] {
		CMD_ADDWF  = 6'd0,
		CMD_ANDWF  = 6'd1,
		CMD_CLRF   = 6'd2,
		CMD_CLRW   = 6'd3,
		CMD_COMF   = 6'd4,
		CMD_DECF   = 6'd5,
		CMD_DECFSZ = 6'd6,
		CMD_INCF   = 6'd7,
		CMD_INCFSZ = 6'd8,
		CMD_IORWF  = 6'd9,
		CMD_MOVF   = 6'd10,
		CMD_MOVWF  = 6'd11,
		CMD_NOP    = 6'd12,
		CMD_RLF    = 6'd13,
		CMD_RRF    = 6'd14,
		CMD_SUBWF  = 6'd15,
		CMD_SWAPF  = 6'd16,
		CMD_XORWF  = 6'd17,
		CMD_BCF    = 6'd18,
		CMD_BSF    = 6'd19,
		CMD_BTFSC  = 6'd20,
		CMD_BTFSS  = 6'd21,
		CMD_ANDLW  = 6'd22,
		CMD_CALL   = 6'd23,
		CMD_CLRWDT = 6'd24,
		CMD_GOTO   = 6'd25,
		CMD_IORLW  = 6'd26,
		CMD_MOVLW  = 6'd27,
		CMD_OPTION = 6'd28,
		CMD_RETLW  = 6'd29,
		CMD_SLEEP  = 6'd30,
		CMD_TRIS   = 6'd31,
		CMD_XORLW  = 6'd32,
		CMD_ADDLW  = 6'd33,
		CMD_RETFIE = 6'd34,
		CMD_RETURN = 6'd35,
		CMD_SUBLW  = 6'd36
	} cmd_e;

	// Decoded opcode: operand class, base word and whether the core has it.
	typedef struct packed {
		kind_e       kind;
		logic [13:0] base;
		logic        legal;
	} op_info_t;

	// Opcode table for both word widths.
	function automatic op_info_t op_lookup(input logic [5:0] cmd, input logic wide);
		op_info_t    info;
		kind_e       kind;
		logic [13:0] b12;
		logic [13:0] b14;
		logic        ok12;
		logic        ok14;
		kind = KIND_NONE;
		b12  = '0;
		b14  = '0;
		ok12 = 1'b1;
		ok14 = 1'b1;
		case (cmd)
			CMD_ADDWF: begin kind = KIND_FD; b12 = 14'h1c0; b14 = 14'h700; end
			CMD_ANDWF: begin kind = KIND_FD; b12 = 14'h140; b14 = 14'h500; end
			CMD_CLRF: begin kind = KIND_F; b12 = 14'h060; b14 = 14'h180; end
			CMD_CLRW: begin kind = KIND_NONE; b12 = 14'h040; b14 = 14'h100; end
			CMD_COMF: begin kind = KIND_FD; b12 = 14'h240; b14 = 14'h900; end
			CMD_DECF: begin kind = KIND_FD; b12 = 14'h0c0; b14 = 14'h300; end
			CMD_DECFSZ: begin kind = KIND_FD; b12 = 14'h2c0; b14 = 14'hb00; end
			CMD_INCF: begin kind = KIND_FD; b12 = 14'h280; b14 = 14'ha00; end
			CMD_INCFSZ: begin kind = KIND_FD; b12 = 14'h3c0; b14 = 14'hf00; end
			CMD_IORWF: begin kind = KIND_FD; b12 = 14'h100; b14 = 14'h400; end
			CMD_MOVF: begin kind = KIND_FD; b12 = 14'h200; b14 = 14'h800; end
			CMD_MOVWF: begin kind = KIND_F; b12 = 14'h020; b14 = 14'h080; end
			CMD_NOP: begin kind = KIND_NONE; b12 = 14'h000; b14 = 14'h000; end
			CMD_RLF: begin kind = KIND_FD; b12 = 14'h340; b14 = 14'hd00; end
			CMD_RRF: begin kind = KIND_FD; b12 = 14'h300; b14 = 14'hc00; end
			CMD_SUBWF: begin kind = KIND_FD; b12 = 14'h080; b14 = 14'h200; end
			CMD_SWAPF: begin kind = KIND_FD; b12 = 14'h380; b14 = 14'he00; end
			CMD_XORWF: begin kind = KIND_FD; b12 = 14'h180; b14 = 14'h600; end
			CMD_BCF: begin kind = KIND_B; b12 = 14'h400; b14 = 14'h1000; end
			CMD_BSF: begin kind = KIND_B; b12 = 14'h500; b14 = 14'h1400; end
			CMD_BTFSC: begin kind = KIND_B; b12 = 14'h600; b14 = 14'h1800; end
			CMD_BTFSS: begin kind = KIND_B; b12 = 14'h700; b14 = 14'h1c00; end
			CMD_ANDLW: begin kind = KIND_LIT; b12 = 14'he00; b14 = 14'h3900; end
			CMD_CALL: begin kind = KIND_ADDR; b12 = 14'h900; b14 = 14'h2000; end
			CMD_CLRWDT: begin kind = KIND_NONE; b12 = 14'h004; b14 = 14'h0064; end
			CMD_GOTO: begin kind = KIND_ADDR; b12 = 14'ha00; b14 = 14'h2800; end
			CMD_IORLW: begin kind = KIND_LIT; b12 = 14'hd00; b14 = 14'h3800; end
			CMD_MOVLW: begin kind = KIND_LIT; b12 = 14'hc00; b14 = 14'h3000; end
			CMD_OPTION: begin kind = KIND_NONE; b12 = 14'h002; ok14 = 1'b0; end
			CMD_RETLW: begin kind = KIND_LIT; b12 = 14'h800; b14 = 14'h3400; end
			CMD_SLEEP: begin kind = KIND_NONE; b12 = 14'h003; b14 = 14'h0063; end
			CMD_TRIS: begin kind = KIND_TRIS; b12 = 14'h000; ok14 = 1'b0; end
			CMD_XORLW: begin kind = KIND_LIT; b12 = 14'hf00; b14 = 14'h3a00; end
			CMD_ADDLW: begin kind = KIND_LIT; b14 = 14'h3e00; ok12 = 1'b0; end
			CMD_RETFIE: begin kind = KIND_NONE; b14 = 14'h0009; ok12 = 1'b0; end
			CMD_RETURN: begin kind = KIND_NONE; b14 = 14'h0008; ok12 = 1'b0; end
			CMD_SUBLW: begin kind = KIND_LIT; b14 = 14'h3c00; ok12 = 1'b0; end
			default: begin
				ok12 = 1'b0;
				ok14 = 1'b0;
			end
		endcase
		info.kind  = kind;
		info.base  = wide ? b14 : b12;
		info.legal = wide ? ok14 : ok12;
		return info;
	endfunction

endpackage

>>> rtl/mcuenc_cfg.sv
module mcuenc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mcuenc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mcuenc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output mcuenc_pkg::cfg_t                  cfg
);
	import mcuenc_pkg::*;

	cfg_t cfg_q;

	// Register file; each write takes the low bits that the register holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.core_mode      <= CORE_MODE_RST;
			cfg_q.data_bank_bits <= DATA_BANK_BITS_RST;
			cfg_q.code_page_bits <= CODE_PAGE_BITS_RST;
			cfg_q.top_code_page  <= TOP_CODE_PAGE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CORE_MODE:      cfg_q.core_mode      <= cfg_wdata[0];
				REG_DATA_BANK_BITS: cfg_q.data_bank_bits <= cfg_wdata[2:0];
				REG_CODE_PAGE_BITS: cfg_q.code_page_bits <= cfg_wdata[3:0];
				REG_TOP_CODE_PAGE:  cfg_q.top_code_page  <= cfg_wdata[1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/mcuenc_encode.sv
module mcuenc_encode (
	input  mcuenc_pkg::cfg_t      cfg,
	input  mcuenc_pkg::in_beat_t  ins,
	output mcuenc_pkg::out_beat_t res
);
	import mcuenc_pkg::*;

	op_info_t    op;
	logic        wide;
	logic [7:0]  bank_mask_full;
	logic [6:0]  reg_op;
	logic [16:0] page_mask_full;
	logic [15:0] page_mask;
	logic [15:0] addr_masked;
	logic [17:0] prog_size;
	logic [2:0]  pages;
	logic [13:0] code;
	logic [2:0]  status;
	logic        refs;

	assign wide = cfg.core_mode;
	assign op   = op_lookup(ins.cmd, wide);

	// Register operand masked to the data bank size.
	assign bank_mask_full = (8'd1 << cfg.data_bank_bits) - 8'd1;
	assign reg_op         = ins.operand_one[6:0] & bank_mask_full[6:0];

	// Code page mask and the total program size limit.
	assign page_mask_full = (17'd1 << cfg.code_page_bits) - 17'd1;
	assign page_mask      = page_mask_full[15:0];
	assign addr_masked    = ins.operand_one & page_mask;
	assign pages          = {1'b0, cfg.top_code_page} + 3'd1;
	assign prog_size      = {15'd0, pages} << cfg.code_page_bits;

	// Field packing and range checks for each operand class.
	always_comb begin
		code   = op.base;
		status = ST_OK;
		refs   = 1'b0;
		case (op.kind)
			KIND_FD: begin
				code = code | {7'd0, reg_op};
				refs = 1'b1;
				if (ins.operand_two == 8'd1) begin
					code = code | (wide ? 14'h0080 : 14'h0020);
				end else if (ins.operand_two != 8'd0) begin
					status = ST_DEST;
				end
			end
			KIND_F: begin
				code = code | {7'd0, reg_op};
				refs = 1'b1;
			end
			KIND_B: begin
				code = code | {7'd0, reg_op};
				refs = 1'b1;
				if (ins.operand_two > 8'd7) begin
					status = ST_BITNUM;
				end else begin
					code = code | ({11'd0, ins.operand_two[2:0]} << (wide ? 4'd7 : 4'd5));
				end
			end
			KIND_LIT: begin
				if (ins.operand_one > 16'd255) begin
					status = ST_LITERAL;
				end else begin
					code = code | {6'd0, ins.operand_one[7:0]};
				end
			end
			KIND_ADDR: begin
				if ({2'd0, ins.operand_one} >= prog_size) begin
					status = ST_ADDR;
				end else begin
					code = code | addr_masked[13:0];
				end
			end
			KIND_TRIS: begin
				code = code | {7'd0, reg_op};
			end
			default: begin
			end
		endcase

		// A mnemonic the selected core lacks gives an empty word.
		if (!op.legal) begin
			code   = '0;
			status = ST_BADCMD;
			refs   = 1'b0;
		end
	end

	assign res.code_word           = code;
	assign res.status              = status;
	assign res.references_register = refs;

endmodule

>>> rtl/mcu_instruction_word_encoder.sv
// Encodes one instruction (mnemonic index and two operands) per beat into a
// 12-bit or 14-bit instruction word, as core_mode selects, with a status code
// for the first failed operand check and a flag for a data register operand.
// The block takes one instruction every clock cycle while the output is not
// stalled; an accepted instruction passes through the input register and the
// result register, between which the table lookup and field packing sit.
// Either register may hold its beat while the other side stalls. Write the
// configuration registers only while no instruction is in flight.
module mcu_instruction_word_encoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mcuenc_pkg::in_beat_t              in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mcuenc_pkg::out_beat_t             out_data,
	input  logic                              cfg_we,
	input  logic [mcuenc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mcuenc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import mcuenc_pkg::*;

	cfg_t      cfg;
	in_beat_t  in_s1;
	logic      valid_s1;
	out_beat_t enc_res;
	out_beat_t out_s2;
	logic      valid_s2;
	logic      adv_s2;

	mcuenc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Each stage moves on when the stage after it is empty or draining.
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	mcuenc_encode u_encode (
		.cfg (cfg),
		.ins (in_s1),
		.res (enc_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			out_s2 <= enc_res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = out_s2;

endmodule
